/* rtl/tidc_pkg.sv */
package tidc_pkg;

    typedef logic [6:0] t_cls;

    typedef struct packed {
        t_cls cls;
        logic wide;
        logic unknown;
    } t_dec;

    localparam t_cls C_LSL_I     = 7'd0;
    localparam t_cls C_LSR_I     = 7'd1;
    localparam t_cls C_ASR_I     = 7'd2;
    localparam t_cls C_ADD_R     = 7'd3;
    localparam t_cls C_SUB_R     = 7'd4;
    localparam t_cls C_ADD_3I    = 7'd5;
    localparam t_cls C_SUB_3I    = 7'd6;
    localparam t_cls C_MOV_I     = 7'd7;
    localparam t_cls C_CMP_I     = 7'd8;
    localparam t_cls C_ADD_8I    = 7'd9;
    localparam t_cls C_SUB_8I    = 7'd10;
    localparam t_cls C_AND_R     = 7'd11;
    localparam t_cls C_EOR_R     = 7'd12;
    localparam t_cls C_LSL_R     = 7'd13;
    localparam t_cls C_LSR_R     = 7'd14;
    localparam t_cls C_ASR_R     = 7'd15;
    localparam t_cls C_ADC_R     = 7'd16;
    localparam t_cls C_SBC_R     = 7'd17;
    localparam t_cls C_ROR_R     = 7'd18;
    localparam t_cls C_TST_R     = 7'd19;
    localparam t_cls C_RSB_I     = 7'd20;
    localparam t_cls C_CMP_R     = 7'd21;
    localparam t_cls C_CMN_R     = 7'd22;
    localparam t_cls C_ORR_R     = 7'd23;
    localparam t_cls C_MUL       = 7'd24;
    localparam t_cls C_BIC_R     = 7'd25;
    localparam t_cls C_MVN_R     = 7'd26;
    localparam t_cls C_MOV_R     = 7'd27;
    localparam t_cls C_BX        = 7'd28;
    localparam t_cls C_BLX_R     = 7'd29;
    localparam t_cls C_STR_R     = 7'd30;
    localparam t_cls C_STRH_R    = 7'd31;
    localparam t_cls C_STRB_R    = 7'd32;
    localparam t_cls C_LDRSB_R   = 7'd33;
    localparam t_cls C_LDR_R     = 7'd34;
    localparam t_cls C_LDRH_R    = 7'd35;
    localparam t_cls C_LDRB_R    = 7'd36;
    localparam t_cls C_LDRSH_R   = 7'd37;
    localparam t_cls C_STR_I     = 7'd38;
    localparam t_cls C_LDR_I     = 7'd39;
    localparam t_cls C_STRB_I    = 7'd40;
    localparam t_cls C_LDRB_I    = 7'd41;
    localparam t_cls C_STRH_I    = 7'd42;
    localparam t_cls C_LDRH_I    = 7'd43;
    localparam t_cls C_STR_I_REL = 7'd44;
    localparam t_cls C_LDR_I_REL = 7'd45;
    localparam t_cls C_ADD_SP_I  = 7'd46;
    localparam t_cls C_SUB_SP_I  = 7'd47;
    localparam t_cls C_SXTH      = 7'd48;
    localparam t_cls C_SXTB      = 7'd49;
    localparam t_cls C_UXTH      = 7'd50;
    localparam t_cls C_UXTB      = 7'd51;
    localparam t_cls C_PUSH      = 7'd52;
    localparam t_cls C_CPS       = 7'd53;
    localparam t_cls C_REV       = 7'd54;
    localparam t_cls C_REV16     = 7'd55;
    localparam t_cls C_REVSH     = 7'd56;
    localparam t_cls C_POP       = 7'd57;
    localparam t_cls C_BKPT      = 7'd58;
    localparam t_cls C_NOP       = 7'd59;
    localparam t_cls C_YIELD     = 7'd60;
    localparam t_cls C_WFE       = 7'd61;
    localparam t_cls C_WFI       = 7'd62;
    localparam t_cls C_SEV       = 7'd63;
    localparam t_cls C_UDF       = 7'd64;
    localparam t_cls C_SVC       = 7'd65;
    localparam t_cls C_B         = 7'd66;
    localparam t_cls C_MSR_R     = 7'd67;
    localparam t_cls C_DSB       = 7'd68;
    localparam t_cls C_DMB       = 7'd69;
    localparam t_cls C_ISB       = 7'd70;
    localparam t_cls C_MRS       = 7'd71;
    localparam t_cls C_BL        = 7'd72;

    // First halfword has priority; the wide table is only consulted on a miss.
    function automatic t_dec decode(input logic [15:0] hw1, input logic [15:0] hw2);
        t_dec        d;
        logic        narrow;
        logic [31:0] w;
        w         = {hw1, hw2};
        narrow    = 1'b1;
        d.cls     = C_UDF;
        d.wide    = 1'b0;
        d.unknown = 1'b0;
        casez (hw1)
            16'b00000???????????: d.cls = C_LSL_I;
            16'b00001???????????: d.cls = C_LSR_I;
            16'b00010???????????: d.cls = C_ASR_I;
            16'b0001100?????????: d.cls = C_ADD_R;
            16'b0001101?????????: d.cls = C_SUB_R;
            16'b0001110?????????: d.cls = C_ADD_3I;
            16'b0001111?????????: d.cls = C_SUB_3I;
            16'b00100???????????: d.cls = C_MOV_I;
            16'b00101???????????: d.cls = C_CMP_I;
            16'b00110???????????: d.cls = C_ADD_8I;
            16'b00111???????????: d.cls = C_SUB_8I;
            16'b0100000000??????: d.cls = C_AND_R;
            16'b0100000001??????: d.cls = C_EOR_R;
            16'b0100000010??????: d.cls = C_LSL_R;
            16'b0100000011??????: d.cls = C_LSR_R;
            16'b0100000100??????: d.cls = C_ASR_R;
            16'b0100000101??????: d.cls = C_ADC_R;
            16'b0100000110??????: d.cls = C_SBC_R;
            16'b0100000111??????: d.cls = C_ROR_R;
            16'b0100001000??????: d.cls = C_TST_R;
            16'b0100001001??????: d.cls = C_RSB_I;
            16'b0100001010??????: d.cls = C_CMP_R;
            16'b0100001011??????: d.cls = C_CMN_R;
            16'b0100001100??????: d.cls = C_ORR_R;
            16'b0100001101??????: d.cls = C_MUL;
            16'b0100001110??????: d.cls = C_BIC_R;
            16'b0100001111??????: d.cls = C_MVN_R;
            16'b01000100????????: d.cls = C_ADD_R;
            16'b0100010101??????: d.cls = C_CMP_R;
            16'b010001011???????: d.cls = C_CMP_R;
            16'b01000110????????: d.cls = C_MOV_R;
            16'b010001110???????: d.cls = C_BX;
            16'b010001111???????: d.cls = C_BLX_R;
            16'b0101000?????????: d.cls = C_STR_R;
            16'b0101001?????????: d.cls = C_STRH_R;
            16'b0101010?????????: d.cls = C_STRB_R;
            16'b0101011?????????: d.cls = C_LDRSB_R;
            16'b0101100?????????: d.cls = C_LDR_R;
            16'b0101101?????????: d.cls = C_LDRH_R;
            16'b0101110?????????: d.cls = C_LDRB_R;
            16'b0101111?????????: d.cls = C_LDRSH_R;
            16'b01100???????????: d.cls = C_STR_I;
            16'b01101???????????: d.cls = C_LDR_I;
            16'b01110???????????: d.cls = C_STRB_I;
            16'b01111???????????: d.cls = C_LDRB_I;
            16'b10000???????????: d.cls = C_STRH_I;
            16'b10001???????????: d.cls = C_LDRH_I;
            16'b10010???????????: d.cls = C_STR_I_REL;
            16'b10011???????????: d.cls = C_LDR_I_REL;
            16'b101100000???????: d.cls = C_ADD_SP_I;
            16'b101100001???????: d.cls = C_SUB_SP_I;
            16'b1011001000??????: d.cls = C_SXTH;
            16'b1011001001??????: d.cls = C_SXTB;
            16'b1011001010??????: d.cls = C_UXTH;
            16'b1011001011??????: d.cls = C_UXTB;
            16'b1011010?????????: d.cls = C_PUSH;
            16'b10110110011?????: d.cls = C_CPS;
            16'b1011101000??????: d.cls = C_REV;
            16'b1011101001??????: d.cls = C_REV16;
            16'b1011101011??????: d.cls = C_REVSH;
            16'b1011110?????????: d.cls = C_POP;
            16'b10111110????????: d.cls = C_BKPT;
            16'b1011111100000000: d.cls = C_NOP;
            16'b1011111100010000: d.cls = C_YIELD;
            16'b1011111100100000: d.cls = C_WFE;
            16'b1011111100110000: d.cls = C_WFI;
            16'b1011111101000000: d.cls = C_SEV;
            16'b11011110????????: d.cls = C_UDF;
            16'b11011111????????: d.cls = C_SVC;
            16'b1101????????????: d.cls = C_B;
            default:              narrow = 1'b0;
        endcase
        if (!narrow) begin
            d.wide = 1'b1;
            casez (w)
                32'b11110011100?????10?0????????????: d.cls = C_MSR_R;
                32'b111100111011????10?0????0100????: d.cls = C_DSB;
                32'b111100111011????10?0????0101????: d.cls = C_DMB;
                32'b111100111011????10?0????0110????: d.cls = C_ISB;
                32'b11110011111?????10?0????????????: d.cls = C_MRS;
                32'b111101111111????1010????????????: d.cls = C_UDF;
                32'b11110???????????11?1????????????: d.cls = C_BL;
                default: begin
                    d.cls     = C_UDF;
                    d.wide    = 1'b0;
                    d.unknown = 1'b1;
                end
            endcase
        end
        return d;
    endfunction

endpackage

/* rtl/thumb_instruction_class_decoder.sv */
// The input word is registered in r_hw1/r_hw2 and its decoded class in r_out, which holds it until taken.
// Throughput: one word per cycle while downstream is ready; both stages then advance together.
// The decode lies between the two registers: a match on the first halfword, then on the whole word on a miss.
// Reset (synchronous, active low) empties both stages; payload registers are not reset.
module thumb_instruction_class_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_first_half,
    input  logic [15:0]        i_second_half,
    output logic               o_valid,
    input  logic               i_ready,
    output tidc_pkg::t_cls     o_inst_class,
    output logic               o_is_wide,
    output logic               o_is_unknown
);
    import tidc_pkg::*;

    logic        r_in_vld;
    logic [15:0] r_hw1;
    logic [15:0] r_hw2;
    logic        r_out_vld;
    t_dec        r_out;
    t_dec        n_out;
    logic        w_out_adv;
    logic        w_in_adv;

    // Each stage may load when it is empty or its word moves on this cycle.
    assign w_out_adv = !r_out_vld || i_ready;
    assign w_in_adv  = !r_in_vld || w_out_adv;
    assign o_ready   = w_in_adv;

    assign n_out = decode(r_hw1, r_hw2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_adv) begin
                r_in_vld <= i_valid;
            end
            if (w_out_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_valid) begin
            r_hw1 <= i_first_half;
            r_hw2 <= i_second_half;
        end
        if (w_out_adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_inst_class = r_out.cls;
    assign o_is_wide    = r_out.wide;
    assign o_is_unknown = r_out.unknown;

endmodule

/* rtl/tidc_chk.sv */
module tidc_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input logic [15:0]    i_first_half,
    input logic [15:0]    i_second_half,
    input logic           o_valid,
    input logic           i_ready,
    input tidc_pkg::t_cls o_inst_class,
    input logic           o_is_wide,
    input logic           o_is_unknown
);
    import tidc_pkg::*;

    // A stalled result word stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    a_cls_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_inst_class <= C_BL)
        else $error("class out of range");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_unknown |-> o_inst_class == C_UDF && !o_is_wide)
        else $error("unknown word with bad class or wide flag");

    a_wide_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_wide |-> o_inst_class == C_UDF || o_inst_class >= C_MSR_R)
        else $error("wide flag on a narrow class");

    // An empty pipe always takes a new word.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !$past(i_valid && o_ready) && $past(i_rst_n) |-> o_ready)
        else $error("not ready while pipe is empty");

endmodule

bind thumb_instruction_class_decoder tidc_chk u_tidc_chk (.*);
